FILE: rtl/sorted_posting_list_merge_unit_macros.svh
// assertion macros for the posting list merge unit
`ifndef SORTED_POSTING_LIST_MERGE_UNIT_MACROS_SVH
`define SORTED_POSTING_LIST_MERGE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SPLM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("splm assertion failed");
`define SPLM_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("splm assertion failed");
`else
`define SPLM_ASSERT(lbl, clk, rst_n, prop)
`define SPLM_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/splm_pkg.sv
// ----------------------------------------------------------------------------
// splm_pkg
// types and constants shared by the posting list merge unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package splm_pkg;
    localparam int MODE_W        = 2;
    localparam int HIT_COUNT_W   = 24;
    localparam int HIT_RANK_W    = 17;
    localparam int WORD_TOTAL_W  = 24;
    localparam int ACC_W         = 32;
    localparam int ENTRY_TOTAL_W = 7;

    localparam logic [MODE_W-1:0] MODE_AND  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DIFF = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_CMP,
        S_END,
        S_DRAIN_READ,
        S_DRAIN_CMP,
        S_FINISH,
        S_EMIT_READ,
        S_EMIT_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic rd_old;
        logic rd_emit;
        logic pass_old;
        logic match;
        logic insert;
        logic end_total;
        logic finish;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic item_takes;
        logic item_ends;
        logic old_left;
        logic old_lt;
        logic old_eq;
        logic pass_valid;
        logic list_empty;
        logic emit_last;
        logic out_free;
    } status_t;
endpackage
`default_nettype wire

FILE: rtl/sorted_posting_list_merge_unit.sv
// ----------------------------------------------------------------------------
// sorted_posting_list_merge_unit
// merges key-sorted hit lists into an accumulated list, one pass at a time
// ----------------------------------------------------------------------------
//  channel   handshake              word carried
//  input     in_valid / in_ready    one entry of the new sorted list
//  result    out_valid / out_ready  one entry of the merged list
//  config    cfg_valid / cfg_ready  merge mode (union, intersection, difference)
//
// an input word reads and compares each old entry that sorts below its key,
// and skips that walk when its key is ignored; a pass-ending word also drains
// the old entries still left, swaps banks and emits each result, every step
// paced by reads of the two-bank entry store
// results leave through an output register, so the next input word is taken
// while the last result still waits; a stalled result holds the emit loop
// no clearing pass: stored length bounds every read of the store
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_posting_list_merge_unit_macros.svh"
module sorted_posting_list_merge_unit #(
    parameter int LIST_DEPTH      = 64,
    parameter int FILE_INDEX_BITS = 4,
    parameter int DOC_INDEX_BITS  = 24
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [splm_pkg::MODE_W-1:0]        cfg_data,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire                                new_query,
    input  wire                                empty_list,
    input  wire                                last_of_list,
    input  wire  [FILE_INDEX_BITS-1:0]         file_index,
    input  wire  [DOC_INDEX_BITS-1:0]          doc_index,
    input  wire  [splm_pkg::HIT_COUNT_W-1:0]   hit_count,
    input  wire  [splm_pkg::HIT_RANK_W-1:0]    hit_rank,
    input  wire  [splm_pkg::WORD_TOTAL_W-1:0]  word_total,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic [FILE_INDEX_BITS-1:0]         out_file_index,
    output logic [DOC_INDEX_BITS-1:0]          out_doc_index,
    output logic [splm_pkg::ACC_W-1:0]         out_count,
    output logic [splm_pkg::ACC_W-1:0]         out_rank,
    output logic [splm_pkg::ACC_W-1:0]         running_total,
    output logic [splm_pkg::ENTRY_TOTAL_W-1:0] entry_total,
    output logic                               merged_empty,
    output logic                               last_entry,
    output logic                               overflow
);
    import splm_pkg::*;

    cmd_t    cmd;
    status_t st;

    // mode register is always writable; the user must write it only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    // sequencer: merge walk, drain of old tail, bank swap, emit loop
    splm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // store banks, pointers, saturating arithmetic, result register
    splm_datapath #(
        .LIST_DEPTH      (LIST_DEPTH),
        .FILE_INDEX_BITS (FILE_INDEX_BITS),
        .DOC_INDEX_BITS  (DOC_INDEX_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .st             (st),
        .new_query      (new_query),
        .empty_list     (empty_list),
        .last_of_list   (last_of_list),
        .file_index     (file_index),
        .doc_index      (doc_index),
        .hit_count      (hit_count),
        .hit_rank       (hit_rank),
        .word_total     (word_total),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_file_index (out_file_index),
        .out_doc_index  (out_doc_index),
        .out_count      (out_count),
        .out_rank       (out_rank),
        .running_total  (running_total),
        .entry_total    (entry_total),
        .merged_empty   (merged_empty),
        .last_entry     (last_entry),
        .overflow       (overflow)
    );

    // merged list never exceeds one bank
    `SPLM_ASSERT(a_total_bound, clk, rst_n, out_valid |-> (entry_total <= LIST_DEPTH))
    // empty result carries zero fields and closes the pass
    `SPLM_ASSERT(a_empty_form, clk, rst_n, (out_valid && merged_empty) |-> (last_entry && out_count == 0 && out_rank == 0 && entry_total == 0))
    // an accepted word always keeps the sequencer busy in the cycle after it is accepted
    `SPLM_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
endmodule
`default_nettype wire

FILE: rtl/splm_ctrl.sv
// ----------------------------------------------------------------------------
// splm_ctrl
// sequencer for merge, drain and emit phases of a pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module splm_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  splm_pkg::status_t st,
    output splm_pkg::cmd_t    cmd
);
    import splm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (st.item_takes)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    state_next = st.item_ends ? S_END : S_IDLE;
                end
            end
            S_READ:
            begin
                cmd.rd_old = st.old_left;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                priority if (st.old_lt)
                begin
                    cmd.pass_old = 1'b1;
                    state_next   = S_READ;
                end
                else if (st.old_eq)
                begin
                    cmd.match  = 1'b1;
                    state_next = st.item_ends ? S_END : S_IDLE;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = st.item_ends ? S_END : S_IDLE;
                end
            end
            S_END:
            begin
                cmd.end_total = 1'b1;
                state_next    = st.pass_valid ? S_DRAIN_READ : S_FINISH;
            end
            S_DRAIN_READ:
            begin
                if (st.old_left)
                begin
                    cmd.rd_old = 1'b1;
                    state_next = S_DRAIN_CMP;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_DRAIN_CMP:
            begin
                cmd.pass_old = 1'b1;
                state_next   = S_DRAIN_READ;
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_EMIT_READ;
            end
            S_EMIT_READ:
            begin
                cmd.rd_emit = !st.list_empty;
                state_next  = S_EMIT_LOAD;
            end
            S_EMIT_LOAD:
            begin
                if (st.out_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = st.emit_last ? S_IDLE : S_EMIT_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/splm_datapath.sv
// ----------------------------------------------------------------------------
// splm_datapath
// two-bank entry store, pointers, merge arithmetic and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module splm_datapath #(
    parameter int LIST_DEPTH      = 64,
    parameter int FILE_INDEX_BITS = 4,
    parameter int DOC_INDEX_BITS  = 24
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    cfg_we,
    input  wire  [splm_pkg::MODE_W-1:0]            cfg_data,
    input  splm_pkg::cmd_t                         cmd,
    output splm_pkg::status_t                      st,
    input  wire                                    new_query,
    input  wire                                    empty_list,
    input  wire                                    last_of_list,
    input  wire  [FILE_INDEX_BITS-1:0]             file_index,
    input  wire  [DOC_INDEX_BITS-1:0]              doc_index,
    input  wire  [splm_pkg::HIT_COUNT_W-1:0]       hit_count,
    input  wire  [splm_pkg::HIT_RANK_W-1:0]        hit_rank,
    input  wire  [splm_pkg::WORD_TOTAL_W-1:0]      word_total,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [FILE_INDEX_BITS-1:0]             out_file_index,
    output logic [DOC_INDEX_BITS-1:0]              out_doc_index,
    output logic [splm_pkg::ACC_W-1:0]             out_count,
    output logic [splm_pkg::ACC_W-1:0]             out_rank,
    output logic [splm_pkg::ACC_W-1:0]             running_total,
    output logic [splm_pkg::ENTRY_TOTAL_W-1:0]     entry_total,
    output logic                                   merged_empty,
    output logic                                   last_entry,
    output logic                                   overflow
);
    import splm_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int PW = $clog2(LIST_DEPTH + 1);
    localparam int KW = FILE_INDEX_BITS + DOC_INDEX_BITS;
    localparam int MEM_DEPTH = 2 << AW;

    logic [KW-1:0]    key_mem  [0:MEM_DEPTH-1];
    logic [ACC_W-1:0] cnt_mem  [0:MEM_DEPTH-1];
    logic [ACC_W-1:0] rank_mem [0:MEM_DEPTH-1];

    logic [MODE_W-1:0]       mode_reg;
    logic [PW-1:0]           len_reg;
    logic                    bank_reg;
    logic [PW-1:0]           old_ptr_reg;
    logic [PW-1:0]           new_ptr_reg;
    logic [PW-1:0]           emit_idx_reg;
    logic [ACC_W-1:0]        total_reg;
    logic                    ovf_reg;
    logic [KW-1:0]           pkey_reg;
    logic                    pkv_reg;
    logic                    out_valid_reg;

    logic                    it_empty_reg;
    logic                    it_last_reg;
    logic [KW-1:0]           it_key_reg;
    logic [HIT_COUNT_W-1:0]  it_cnt_reg;
    logic [HIT_RANK_W-1:0]   it_rank_reg;
    logic [WORD_TOTAL_W-1:0] it_wt_reg;
    logic [MODE_W-1:0]       it_mode_reg;

    logic [KW-1:0]           rd_key_reg;
    logic [ACC_W-1:0]        rd_cnt_reg;
    logic [ACC_W-1:0]        rd_rank_reg;

    logic                    mode_union;
    logic [AW:0]             rd_addr;
    logic [AW:0]             wr_addr;
    logic                    room;
    logic                    wr_en;
    logic [KW-1:0]           wr_key;
    logic [ACC_W-1:0]        wr_cnt;
    logic [ACC_W-1:0]        wr_rank;
    logic [ACC_W:0]          cnt_sum;
    logic [ACC_W:0]          rank_sum;
    logic [ACC_W+1:0]        rank_dbl;
    logic [ACC_W:0]          total_sum;
    logic [PW:0]             pending;

    assign mode_union = (it_mode_reg != MODE_AND) && (it_mode_reg != MODE_DIFF);

    // combine on matching key
    assign cnt_sum  = {1'b0, rd_cnt_reg} + (ACC_W+1)'(it_cnt_reg);
    assign rank_sum = {1'b0, rd_rank_reg} + (ACC_W+1)'(it_rank_reg);
    assign rank_dbl = {rank_sum, 1'b0};
    assign total_sum = {1'b0, total_reg} + (ACC_W+1)'(it_wt_reg);

    // insert only while the old entries still left keep a slot
    assign pending = {1'b0, new_ptr_reg} + ({1'b0, len_reg} - {1'b0, old_ptr_reg});
    assign room    = pending < (PW+1)'(LIST_DEPTH);

    always_comb
    begin
        wr_key  = rd_key_reg;
        wr_cnt  = rd_cnt_reg;
        wr_rank = rd_rank_reg;
        wr_en   = 1'b0;
        priority if (cmd.pass_old)
        begin
            wr_en = (it_mode_reg != MODE_AND);
        end
        else if (cmd.match)
        begin
            wr_en   = (it_mode_reg != MODE_DIFF);
            wr_key  = it_key_reg;
            wr_cnt  = cnt_sum[ACC_W] ? '1 : cnt_sum[ACC_W-1:0];
            wr_rank = (rank_dbl[ACC_W+1:ACC_W] != 2'b00) ? '1 : rank_dbl[ACC_W-1:0];
        end
        else if (cmd.insert)
        begin
            wr_en   = mode_union && room;
            wr_key  = it_key_reg;
            wr_cnt  = ACC_W'(it_cnt_reg);
            wr_rank = ACC_W'(it_rank_reg);
        end
        else
        begin
            wr_en = 1'b0;
        end
        wr_en = wr_en && (new_ptr_reg < PW'(LIST_DEPTH));
    end

    assign wr_addr = {~bank_reg, new_ptr_reg[AW-1:0]};
    assign rd_addr = cmd.rd_emit ? {bank_reg, emit_idx_reg[AW-1:0]}
                                 : {bank_reg, old_ptr_reg[AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]  <= wr_key;
            cnt_mem[wr_addr]  <= wr_cnt;
            rank_mem[wr_addr] <= wr_rank;
        end
        if (cmd.rd_old || cmd.rd_emit)
        begin
            rd_key_reg  <= key_mem[rd_addr];
            rd_cnt_reg  <= cnt_mem[rd_addr];
            rd_rank_reg <= rank_mem[rd_addr];
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            it_empty_reg <= empty_list;
            it_last_reg  <= last_of_list;
            it_key_reg   <= {file_index, doc_index};
            it_cnt_reg   <= hit_count;
            it_rank_reg  <= hit_rank;
            it_wt_reg    <= word_total;
            it_mode_reg  <= mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= '0;
            len_reg      <= '0;
            bank_reg     <= 1'b0;
            old_ptr_reg  <= '0;
            new_ptr_reg  <= '0;
            emit_idx_reg <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            pkey_reg     <= '0;
            pkv_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.accept && new_query)
            begin
                len_reg     <= '0;
                total_reg   <= '0;
                ovf_reg     <= 1'b0;
                old_ptr_reg <= '0;
                new_ptr_reg <= '0;
                pkv_reg     <= 1'b0;
            end
            if (cmd.pass_old || cmd.match)
            begin
                old_ptr_reg <= old_ptr_reg + PW'(1);
            end
            if (cmd.match || cmd.insert)
            begin
                pkey_reg <= it_key_reg;
                pkv_reg  <= 1'b1;
            end
            if (cmd.insert && mode_union && !room)
            begin
                ovf_reg <= 1'b1;
            end
            if (wr_en)
            begin
                new_ptr_reg <= new_ptr_reg + PW'(1);
            end
            if (cmd.end_total)
            begin
                total_reg <= total_sum[ACC_W] ? '1 : total_sum[ACC_W-1:0];
            end
            if (cmd.finish)
            begin
                if (pkv_reg)
                begin
                    len_reg  <= new_ptr_reg;
                    bank_reg <= ~bank_reg;
                end
                old_ptr_reg  <= '0;
                new_ptr_reg  <= '0;
                pkv_reg      <= 1'b0;
                emit_idx_reg <= '0;
            end
            if (cmd.emit_load)
            begin
                emit_idx_reg <= emit_idx_reg + PW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            running_total <= total_reg;
            overflow      <= ovf_reg;
            entry_total   <= ENTRY_TOTAL_W'(len_reg);
            if (len_reg == '0)
            begin
                out_file_index <= '0;
                out_doc_index  <= '0;
                out_count      <= '0;
                out_rank       <= '0;
                merged_empty   <= 1'b1;
                last_entry     <= 1'b1;
            end
            else
            begin
                out_file_index <= rd_key_reg[KW-1:DOC_INDEX_BITS];
                out_doc_index  <= rd_key_reg[DOC_INDEX_BITS-1:0];
                out_count      <= rd_cnt_reg;
                out_rank       <= rd_rank_reg;
                merged_empty   <= 1'b0;
                last_entry     <= (emit_idx_reg + PW'(1)) == len_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        st.item_takes = !it_empty_reg && !(pkv_reg && (it_key_reg <= pkey_reg));
        st.item_ends  = it_empty_reg || it_last_reg;
        st.old_left   = old_ptr_reg < len_reg;
        st.old_lt     = st.old_left && (rd_key_reg < it_key_reg);
        st.old_eq     = st.old_left && (rd_key_reg == it_key_reg);
        st.pass_valid = pkv_reg;
        st.list_empty = (len_reg == '0);
        st.emit_last  = (len_reg == '0) || ((emit_idx_reg + PW'(1)) == len_reg);
        st.out_free   = !out_valid_reg || out_ready;
    end
endmodule
`default_nettype wire
